### hdl/oclw_pkg.sv
// package for the object cache tag and policy controller
// constants, beat structs, result codes and the extent update function
// no dependencies
`default_nettype none

package oclw_pkg;

  localparam int ENTRIES = 31;
  localparam int ID_BITS = 16;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int RANK_W = IDX_W;
  localparam int EXT_W  = ID_BITS + 1;
  localparam int CMP_W  = (ID_BITS > CNT_W) ? ID_BITS : CNT_W;

  localparam int CMD_W  = 2;
  localparam int OBJ_W  = 16;
  localparam int KIND_W = 3;
  localparam int SLOT_W = 5;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GROW  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_HIT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FILL  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ZERO  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WB    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BLANK = 3'd4;

  typedef enum logic [1:0] {
    CMP_EQ,
    CMP_GE,
    CMP_LT
  } cmp_op_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [OBJ_W-1:0] object_id;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OBJ_W-1:0]  record_id;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } out_item_t;

  // raise the store extent so that record id lies inside it
  function automatic logic [EXT_W-1:0] ext_grow(input logic [EXT_W-1:0] ext,
                                                input logic [ID_BITS-1:0] id);
    logic [EXT_W-1:0] need;
    need = EXT_W'(id) + EXT_W'(2);
    return (need > ext) ? need : ext;
  endfunction

endpackage

`default_nettype wire

### hdl/oclw_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module oclw_ram #(
  parameter int Width = 16,
  parameter int Depth = 31
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/oclw_cmp.sv
// shared compare unit of the cache walk: tag match, victim rank, recency aging
// depends on oclw_pkg
`default_nettype none

module oclw_cmp (
  input  wire oclw_pkg::cmp_op_e                op_i,
  input  wire logic [oclw_pkg::CMP_W-1:0]       a_i,
  input  wire logic [oclw_pkg::CMP_W-1:0]       b_i,
  output logic                                  hit_o
);

  always_comb begin
    case (op_i)
      oclw_pkg::CMP_EQ: hit_o = (a_i == b_i);
      oclw_pkg::CMP_GE: hit_o = (a_i >= b_i);
      oclw_pkg::CMP_LT: hit_o = (a_i < b_i);
      default:          hit_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/object_cache_lru_writeback.sv
// Tag and policy controller of a fully associative, 31-entry object cache with LRU
// replacement and writeback. One item is taken at a time; a sequencer walks the entries one
// per cycle, if not held, through a single-read-port tag ram and rank ram and one shared
// comparator: a hit walks the lookup to its entry, then the aging walk; a fill into a free
// entry, the full lookup and aging walk; a miss on a full cache adds the victim walk; a grow
// on a full cache runs the flush walk. Each result beat waits in an output register while
// stalled, and the sequencer holds whenever a new beat meets a stalled full register.
// depends on oclw_pkg, oclw_ram, oclw_cmp
`default_nettype none

module object_cache_lru_writeback (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire oclw_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output oclw_pkg::out_item_t      out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_VICT,
    S_WB,
    S_FILL,
    S_TOUCH,
    S_FLUSH,
    S_BLANK
  } state_e;

  state_e                              state_q, state_d;
  logic [oclw_pkg::CNT_W-1:0]          k_q, k_d;
  logic [oclw_pkg::IDX_W-1:0]          e_q, e_d;
  logic [oclw_pkg::CNT_W-1:0]          old_q, old_d;
  logic [oclw_pkg::RANK_W-1:0]         best_q, best_d;
  logic                                hit_q, hit_d;
  logic [oclw_pkg::CMD_W-1:0]          cmd_q, cmd_d;
  logic [oclw_pkg::ID_BITS-1:0]        id_q, id_d;
  logic [oclw_pkg::ID_BITS-1:0]        vtag_q, vtag_d;
  logic [oclw_pkg::CNT_W-1:0]          in_use_q, in_use_d;
  logic [oclw_pkg::EXT_W-1:0]          ext_q, ext_d;
  logic [oclw_pkg::ENTRIES-1:0]        dirty_q, dirty_d;
  logic                                out_valid_q, out_valid_d;
  oclw_pkg::out_item_t                 out_q, out_d;

  logic [oclw_pkg::ID_BITS-1:0]        tag_rdata;
  logic [oclw_pkg::RANK_W-1:0]         rank_rdata;
  logic                                tag_we, rank_we;
  logic [oclw_pkg::RANK_W-1:0]         rank_wdata;
  logic [oclw_pkg::IDX_W-1:0]          k_idx;
  logic [oclw_pkg::IDX_W-1:0]          raddr;

  oclw_pkg::cmp_op_e                   cmp_op;
  logic [oclw_pkg::CMP_W-1:0]          cmp_a, cmp_b;
  logic                                cmp_hit;
  logic                                out_free;

  assign k_idx      = k_q[oclw_pkg::IDX_W-1:0];
  assign raddr      = k_d[oclw_pkg::IDX_W-1:0];
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  oclw_ram #(
    .Width(oclw_pkg::ID_BITS),
    .Depth(oclw_pkg::ENTRIES)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (tag_we),
    .waddr_i(e_q),
    .wdata_i(id_q),
    .raddr_i(raddr),
    .rdata_o(tag_rdata)
  );

  oclw_ram #(
    .Width(oclw_pkg::RANK_W),
    .Depth(oclw_pkg::ENTRIES)
  ) u_rank_ram (
    .clk_i  (clk_i),
    .we_i   (rank_we),
    .waddr_i(k_idx),
    .wdata_i(rank_wdata),
    .raddr_i(raddr),
    .rdata_o(rank_rdata)
  );

  oclw_cmp u_cmp (
    .op_i (cmp_op),
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .hit_o(cmp_hit)
  );

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    e_d         = e_q;
    old_d       = old_q;
    best_d      = best_q;
    hit_d       = hit_q;
    cmd_d       = cmd_q;
    id_d        = id_q;
    vtag_d      = vtag_q;
    in_use_d    = in_use_q;
    ext_d       = ext_q;
    dirty_d     = dirty_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    tag_we      = 1'b0;
    rank_we     = 1'b0;
    rank_wdata  = '0;
    cmp_op      = oclw_pkg::CMP_EQ;
    cmp_a       = oclw_pkg::CMP_W'(tag_rdata);
    cmp_b       = oclw_pkg::CMP_W'(id_q);

    case (state_q)
      S_IDLE: begin
        k_d = '0;
        if (in_valid_i) begin
          cmd_d = in_data_i.command;
          id_d  = oclw_pkg::ID_BITS'(in_data_i.object_id);
          if (in_data_i.command == oclw_pkg::CMD_GROW) begin
            if (in_use_q == oclw_pkg::CNT_W'(oclw_pkg::ENTRIES)) begin
              state_d = S_FLUSH;
            end else begin
              state_d = S_BLANK;
            end
          end else if (in_data_i.command != oclw_pkg::CMD_NONE) begin
            state_d = S_LOOK;
          end
        end
      end

      S_LOOK: begin
        if (k_q >= in_use_q) begin
          hit_d = 1'b0;
          old_d = oclw_pkg::CNT_W'(oclw_pkg::ENTRIES);
          if (in_use_q < oclw_pkg::CNT_W'(oclw_pkg::ENTRIES)) begin
            e_d      = in_use_q[oclw_pkg::IDX_W-1:0];
            in_use_d = in_use_q + oclw_pkg::CNT_W'(1);
            state_d  = S_FILL;
          end else begin
            k_d     = '0;
            best_d  = '0;
            state_d = S_VICT;
          end
        end else if (cmp_hit) begin
          hit_d   = 1'b1;
          e_d     = k_idx;
          old_d   = oclw_pkg::CNT_W'(rank_rdata);
          state_d = S_FILL;
        end else begin
          k_d = k_q + oclw_pkg::CNT_W'(1);
        end
      end

      S_VICT: begin
        cmp_op = oclw_pkg::CMP_GE;
        cmp_a  = oclw_pkg::CMP_W'(rank_rdata);
        cmp_b  = oclw_pkg::CMP_W'(best_q);
        if (cmp_hit) begin
          best_d = rank_rdata;
          e_d    = k_idx;
          vtag_d = tag_rdata;
        end
        if (k_q == oclw_pkg::CNT_W'(oclw_pkg::ENTRIES - 1)) begin
          state_d = S_WB;
        end else begin
          k_d = k_q + oclw_pkg::CNT_W'(1);
        end
      end

      S_WB: begin
        if (!dirty_q[e_q]) begin
          state_d = S_FILL;
        end else if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.kind      = oclw_pkg::KIND_WB;
          out_d.record_id = oclw_pkg::OBJ_W'(vtag_q);
          out_d.slot      = oclw_pkg::SLOT_W'(e_q);
          out_d.last      = 1'b0;
          ext_d           = oclw_pkg::ext_grow(ext_q, vtag_q);
          state_d         = S_FILL;
        end
      end

      S_FILL: begin
        k_d = '0;
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.record_id = oclw_pkg::OBJ_W'(id_q);
          out_d.slot      = oclw_pkg::SLOT_W'(e_q);
          out_d.last      = 1'b1;
          if (hit_q) begin
            out_d.kind = oclw_pkg::KIND_HIT;
            if (cmd_q == oclw_pkg::CMD_WRITE) begin
              dirty_d[e_q] = 1'b1;
            end
          end else begin
            if ((oclw_pkg::EXT_W'(id_q) + oclw_pkg::EXT_W'(1)) < ext_q) begin
              out_d.kind = oclw_pkg::KIND_FILL;
            end else begin
              out_d.kind = oclw_pkg::KIND_ZERO;
            end
            tag_we       = 1'b1;
            dirty_d[e_q] = (cmd_q == oclw_pkg::CMD_WRITE);
          end
          state_d = S_TOUCH;
        end
      end

      S_TOUCH: begin
        cmp_op = oclw_pkg::CMP_LT;
        cmp_a  = oclw_pkg::CMP_W'(rank_rdata);
        cmp_b  = oclw_pkg::CMP_W'(old_q);
        if (k_idx == e_q) begin
          rank_we    = 1'b1;
          rank_wdata = '0;
        end else if (cmp_hit) begin
          rank_we    = 1'b1;
          rank_wdata = rank_rdata + oclw_pkg::RANK_W'(1);
        end
        if (k_q == in_use_q - oclw_pkg::CNT_W'(1)) begin
          state_d = S_IDLE;
        end else begin
          k_d = k_q + oclw_pkg::CNT_W'(1);
        end
      end

      S_FLUSH: begin
        if (!dirty_q[k_idx] || out_free) begin
          if (dirty_q[k_idx]) begin
            out_valid_d     = 1'b1;
            out_d.kind      = oclw_pkg::KIND_WB;
            out_d.record_id = oclw_pkg::OBJ_W'(tag_rdata);
            out_d.slot      = oclw_pkg::SLOT_W'(k_idx);
            out_d.last      = 1'b0;
            ext_d           = oclw_pkg::ext_grow(ext_q, tag_rdata);
            dirty_d[k_idx]  = 1'b0;
          end
          if (k_q == oclw_pkg::CNT_W'(oclw_pkg::ENTRIES - 1)) begin
            in_use_d = '0;
            state_d  = S_BLANK;
          end else begin
            k_d = k_q + oclw_pkg::CNT_W'(1);
          end
        end
      end

      S_BLANK: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.kind      = oclw_pkg::KIND_BLANK;
          out_d.record_id = oclw_pkg::OBJ_W'(id_q);
          out_d.slot      = '0;
          out_d.last      = 1'b1;
          ext_d           = oclw_pkg::ext_grow(ext_q, id_q);
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      in_use_q    <= '0;
      ext_q       <= '0;
      dirty_q     <= '0;
      out_valid_q <= 1'b0;
      e_q         <= '0;
      old_q       <= '0;
      best_q      <= '0;
      hit_q       <= 1'b0;
      cmd_q       <= oclw_pkg::CMD_READ;
      id_q        <= '0;
      vtag_q      <= '0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      in_use_q    <= in_use_d;
      ext_q       <= ext_d;
      dirty_q     <= dirty_d;
      out_valid_q <= out_valid_d;
      e_q         <= e_d;
      old_q       <= old_d;
      best_q      <= best_d;
      hit_q       <= hit_d;
      cmd_q       <= cmd_d;
      id_q        <= id_d;
      vtag_q      <= vtag_d;
      out_q       <= out_d;
    end
  end

  // occupancy never passes the entry count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_use_q <= oclw_pkg::CNT_W'(oclw_pkg::ENTRIES))
    else $error("entry count overflow");

  // a writeback beat never closes an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.kind == oclw_pkg::KIND_WB) |-> !out_q.last)
    else $error("writeback marked last");

  // the aging walk stays inside the occupied entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TOUCH) |-> (k_q < in_use_q))
    else $error("touch walk out of range");

  // a finished flush leaves no dirty entry and an empty cache
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BLANK) && ($past(state_q) == S_FLUSH) |-> (dirty_q == '0) && (in_use_q == '0))
    else $error("flush left dirty entries");

  // an accepted access starts with the tag lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && ((in_data_i.command == oclw_pkg::CMD_READ) ||
    (in_data_i.command == oclw_pkg::CMD_WRITE)) |=> (state_q == S_LOOK))
    else $error("access did not start lookup");

endmodule

`default_nettype wire

### dv/tb_object_cache_lru_writeback.sv
// testbench for object_cache_lru_writeback: directed and random object accesses and grows
// checked against a cycle-free model of the lru tag, dirty and store extent state
// depends on oclw_pkg and the object_cache_lru_writeback rtl
module tb_object_cache_lru_writeback;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  oclw_pkg::in_item_t  in_beat = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  oclw_pkg::out_item_t out_beat;

  bit idle_en = 1'b0;
  int stall_left = 0;
  int error_count = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int hit_count = 0;
  int writeback_count = 0;
  int zero_fill_count = 0;
  int flush_count = 0;

  // cache state as the block should hold it
  logic [oclw_pkg::OBJ_W-1:0]  cached_tag [oclw_pkg::ENTRIES];
  logic                        cached_dirty [oclw_pkg::ENTRIES];
  logic [oclw_pkg::RANK_W-1:0] cached_rank [oclw_pkg::ENTRIES];
  logic [oclw_pkg::CNT_W-1:0]  entries_used = '0;
  logic [oclw_pkg::EXT_W-1:0]  store_extent = '0;

  oclw_pkg::out_item_t expected_beats[$];

  object_cache_lru_writeback i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic oclw_pkg::out_item_t make_result(
      input logic [oclw_pkg::KIND_W-1:0] kind,
      input logic [oclw_pkg::OBJ_W-1:0] id, input int slot);
    oclw_pkg::out_item_t r;
    r.kind      = kind;
    r.record_id = id;
    r.slot      = oclw_pkg::SLOT_W'(slot);
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic void raise_extent(input logic [oclw_pkg::OBJ_W-1:0] id);
    int need;
    need = int'(id) + 2;
    if (need > int'(store_extent)) begin
      store_extent = oclw_pkg::EXT_W'(need);
    end
  endfunction

  // make entry e most recent, entries younger than old_rank age by one
  function automatic void promote(input int e, input int old_rank);
    int k;
    for (k = 0; k < int'(entries_used); k++) begin
      if (k != e && int'(cached_rank[k]) < old_rank) begin
        cached_rank[k] = cached_rank[k] + 1'b1;
      end
    end
    cached_rank[e] = '0;
  endfunction

  function automatic void predict_cache_results(input logic [oclw_pkg::CMD_W-1:0] cmd,
                                                input logic [oclw_pkg::OBJ_W-1:0] id);
    oclw_pkg::out_item_t beats[$];
    int                  e;
    int                  k;
    int                  oldest;
    if (cmd == oclw_pkg::CMD_NONE) begin
      return;
    end
    if (cmd == oclw_pkg::CMD_GROW) begin
      if (int'(entries_used) >= oclw_pkg::ENTRIES) begin
        for (k = 0; k < oclw_pkg::ENTRIES; k++) begin
          if (cached_dirty[k]) begin
            beats.push_back(make_result(oclw_pkg::KIND_WB, cached_tag[k], k));
            raise_extent(cached_tag[k]);
          end
          cached_dirty[k] = 1'b0;
        end
        entries_used = '0;
      end
      beats.push_back(make_result(oclw_pkg::KIND_BLANK, id, 0));
      raise_extent(id);
    end else begin
      e = -1;
      for (k = 0; k < int'(entries_used); k++) begin
        if (e < 0 && cached_tag[k] == id) begin
          e = k;
        end
      end
      if (e >= 0) begin
        promote(e, int'(cached_rank[e]));
        beats.push_back(make_result(oclw_pkg::KIND_HIT, id, e));
      end else begin
        if (int'(entries_used) < oclw_pkg::ENTRIES) begin
          e = int'(entries_used);
          entries_used = entries_used + 1'b1;
          promote(e, oclw_pkg::ENTRIES + 1);
        end else begin
          oldest = 0;
          e = 0;
          for (k = 0; k < oclw_pkg::ENTRIES; k++) begin
            if (int'(cached_rank[k]) >= oldest) begin
              oldest = int'(cached_rank[k]);
              e = k;
            end
          end
          if (cached_dirty[e]) begin
            beats.push_back(make_result(oclw_pkg::KIND_WB, cached_tag[e], e));
            raise_extent(cached_tag[e]);
          end
          promote(e, oclw_pkg::ENTRIES + 1);
        end
        cached_tag[e] = id;
        cached_dirty[e] = 1'b0;
        beats.push_back(make_result((int'(id) + 1 < int'(store_extent)) ?
                                    oclw_pkg::KIND_FILL : oclw_pkg::KIND_ZERO, id, e));
      end
      if (cmd == oclw_pkg::CMD_WRITE) begin
        cached_dirty[e] = 1'b1;
      end
    end
    beats[beats.size() - 1].last = 1'b1;
    foreach (beats[i]) begin
      expected_beats.push_back(beats[i]);
    end
  endfunction

  task automatic send_item(input logic [oclw_pkg::CMD_W-1:0] cmd,
                           input logic [oclw_pkg::OBJ_W-1:0] id);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{command: cmd, object_id: id};
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_cache_results(cmd, id);
    beats_sent++;
  endtask

  task automatic wait_drained();
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic test_field_extremes();
    send_item(oclw_pkg::CMD_READ, 16'h0000);
    send_item(oclw_pkg::CMD_WRITE, 16'hFFFF);
    send_item(oclw_pkg::CMD_NONE, 16'h1234);
    send_item(oclw_pkg::CMD_GROW, 16'h0000);
    send_item(oclw_pkg::CMD_READ, 16'h0000);
    send_item(oclw_pkg::CMD_READ, 16'hFFFF);
    send_item(oclw_pkg::CMD_GROW, 16'h0028);
    send_item(oclw_pkg::CMD_READ, 16'h0014);
    send_item(oclw_pkg::CMD_WRITE, 16'h0000);
    send_item(oclw_pkg::CMD_WRITE, 16'hAAAA);
    send_item(oclw_pkg::CMD_READ, 16'h5555);
    send_item(oclw_pkg::CMD_NONE, 16'hFFFF);
    send_item(oclw_pkg::CMD_WRITE, 16'h0014);
  endtask

  task automatic test_lru_eviction();
    int n;
    n = 0;
    while (int'(entries_used) < oclw_pkg::ENTRIES) begin
      send_item((n % 3 == 0) ? oclw_pkg::CMD_READ : oclw_pkg::CMD_WRITE, 16'h0200 + 16'(n));
      n++;
    end
    send_item(oclw_pkg::CMD_READ, 16'h0000);
    send_item(oclw_pkg::CMD_WRITE, 16'hFFFF);
    repeat (4) begin
      send_item(oclw_pkg::CMD_READ, 16'h0280 + 16'(n));
      n++;
    end
    send_item(oclw_pkg::CMD_WRITE, 16'h0280);
  endtask

  task automatic test_flush_on_grow();
    int n;
    n = 0;
    while (int'(entries_used) < oclw_pkg::ENTRIES) begin
      send_item(oclw_pkg::CMD_WRITE, 16'h0300 + 16'(n));
      n++;
    end
    send_item(oclw_pkg::CMD_GROW, 16'h0340);
    send_item(oclw_pkg::CMD_GROW, 16'h0341);
    send_item(oclw_pkg::CMD_READ, 16'h0202);
    send_item(oclw_pkg::CMD_READ, 16'h0900);
  endtask

  task automatic test_drain_pause();
    repeat (20) send_item(oclw_pkg::CMD_W'($urandom_range(0, 1)),
                          16'h0100 + 16'($urandom_range(0, 39)));
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (20) send_item(oclw_pkg::CMD_W'($urandom_range(0, 2)),
                          16'h0100 + 16'($urandom_range(0, 39)));
  endtask

  task automatic test_random_traffic(input int n_items);
    int                          sent;
    int                          pick;
    logic [oclw_pkg::OBJ_W-1:0]  base;
    logic [oclw_pkg::CMD_W-1:0]  cmd;
    logic [oclw_pkg::OBJ_W-1:0]  id;
    sent = 0;
    while (sent < n_items) begin
      idle_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: base = 16'h0000;
        1: base = 16'h0180;
        2: base = 16'($urandom_range(0, 16'h3FFF));
        default: base = 16'($urandom);
      endcase
      repeat ($urandom_range(10, 40)) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          cmd = oclw_pkg::CMD_READ;
        end else if (pick < 85) begin
          cmd = oclw_pkg::CMD_WRITE;
        end else if (pick < 95) begin
          cmd = oclw_pkg::CMD_GROW;
        end else begin
          cmd = oclw_pkg::CMD_NONE;
        end
        id = base + 16'($urandom_range(0, 39));
        if ($urandom_range(0, 19) == 0) begin
          id = 16'($urandom);
        end
        if (cmd == oclw_pkg::CMD_GROW) begin
          id = id >> 2;
        end
        send_item(cmd, id);
        if (cmd != oclw_pkg::CMD_NONE) begin
          sent++;
        end
      end
    end
  endtask

  task automatic test_streaming_tail();
    idle_en = 1'b0;
    repeat (40) send_item(oclw_pkg::CMD_W'($urandom_range(0, 1)),
                          16'h0400 + 16'($urandom_range(0, 35)));
    send_item(oclw_pkg::CMD_GROW, 16'hFFFF);
    send_item(oclw_pkg::CMD_READ, 16'hFFFE);
    send_item(oclw_pkg::CMD_WRITE, 16'h0401);
  endtask

  // result side stall bursts
  always @(negedge clk) begin
    if (idle_en && stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_stall  <= 1'b1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    oclw_pkg::out_item_t exp_beat;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      beats_checked++;
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat kind %0d id %h slot %0d",
                                  out_beat.kind, out_beat.record_id, out_beat.slot));
      end else begin
        exp_beat = expected_beats.pop_front();
        if (out_beat.kind !== exp_beat.kind)
          report_mismatch($sformatf("kind %0d, expected %0d (id %h)",
                                    out_beat.kind, exp_beat.kind, exp_beat.record_id));
        if (out_beat.record_id !== exp_beat.record_id)
          report_mismatch($sformatf("record_id %h, expected %h",
                                    out_beat.record_id, exp_beat.record_id));
        if (out_beat.slot !== exp_beat.slot)
          report_mismatch($sformatf("slot %0d, expected %0d (id %h)",
                                    out_beat.slot, exp_beat.slot, exp_beat.record_id));
        if (out_beat.last !== exp_beat.last)
          report_mismatch($sformatf("last %b, expected %b (id %h)",
                                    out_beat.last, exp_beat.last, exp_beat.record_id));
        case (exp_beat.kind)
          oclw_pkg::KIND_HIT:  hit_count++;
          oclw_pkg::KIND_WB:   writeback_count++;
          oclw_pkg::KIND_ZERO: zero_fill_count++;
          oclw_pkg::KIND_BLANK: if (exp_beat.last && writeback_count > 0) flush_count++;
          default: ;
        endcase
      end
    end
  end

  initial begin
    foreach (cached_tag[i]) begin
      cached_tag[i]   = '0;
      cached_dirty[i] = 1'b0;
      cached_rank[i]  = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_en = 1'b1;
    test_field_extremes();
    test_lru_eviction();
    test_flush_on_grow();
    test_drain_pause();
    test_random_traffic(320);
    test_streaming_tail();

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (300) @(posedge clk);

    $display("covered %0d input beats and %0d result beats", beats_sent, beats_checked);
    $display("  %0d hits, %0d zero fills, %0d writebacks", hit_count, zero_fill_count,
             writeback_count);
    if (error_count == 0 && expected_beats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
